// ===== rtl/diffusion_stencil_3d_assert.svh =====
// Assertion macros for the stencil block.
`ifndef DIFFUSION_STENCIL_3D_ASSERT_SVH
`define DIFFUSION_STENCIL_3D_ASSERT_SVH

// Clocked property, masked while in reset.
`define DS3_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("stencil assertion failed");

// Same, with a message of its own.
`define DS3_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

// ===== rtl/ds3_pkg.sv =====
// ----------------------------------------------------------------------------
// ds3_pkg
// Shared constants and types of the 3-D seven-point stencil.
// ----------------------------------------------------------------------------
package ds3_pkg;

  localparam int unsigned MaxRowLenDef = 256;
  localparam int unsigned MaxRowsDef   = 256;

  localparam int unsigned DataW = 32;
  localparam int unsigned ProdW = 52;  // signed, holds +-2^50

  localparam logic [31:0] CoefRst = 32'd6554;
  localparam logic [8:0]  SizeXYRst = 9'd256;
  localparam logic [15:0] SizeZRst  = 16'd256;

  typedef enum logic [2:0] {
    CFG_VISC   = 3'd0,
    CFG_COEF_X = 3'd1,
    CFG_COEF_Y = 3'd2,
    CFG_COEF_Z = 3'd3,
    CFG_SIZE_X = 3'd4,
    CFG_SIZE_Y = 3'd5,
    CFG_SIZE_Z = 3'd6
  } cfg_reg_e;

  // Per-item flags from the position tracker
  typedef struct packed {
    logic emit;
    logic inter;
  } pos_flags_t;

  // Sideband traveling with an item down the pipe
  typedef struct packed {
    logic              inter;
    logic signed [31:0] tend;
  } side_t;

endpackage

// ===== rtl/diffusion_stencil_3d.sv =====
// Register path: window read, differences, axis mulq, sum, visc mulq, output.
// Throughput: one sample per cycle; the pipe stalls as a whole when the
// output register is full and not taken.
// Reset (rst_ni low, async) clears the position counters, valid bits and
// loads register reset values; window contents stay undefined until written.
// ----------------------------------------------------------------------------
// diffusion_stencil_3d
// Streamed seven-point 3-D Laplacian diffusion stencil, Q16.16.
// ----------------------------------------------------------------------------
module diffusion_stencil_3d import ds3_pkg::*; #(
  parameter int unsigned MAX_ROW_LEN = MaxRowLenDef,
  parameter int unsigned MAX_ROWS    = MaxRowsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // field_value, tend_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // tend_out, interior, saturated, zero pad
);

  localparam int unsigned AW = 1 + $clog2(MAX_ROW_LEN) + $clog2(MAX_ROWS);
  localparam int unsigned SideN = 11;

  logic [31:0] visc_q, cx_q, cy_q, cz_q;
  logic [8:0]  sx_q, sy_q;
  logic [15:0] sz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visc_q <= CoefRst; cx_q <= CoefRst; cy_q <= CoefRst; cz_q <= CoefRst;
      sx_q <= SizeXYRst; sy_q <= SizeXYRst; sz_q <= SizeZRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_VISC:   visc_q <= cfg_data_i;
        CFG_COEF_X: cx_q   <= cfg_data_i;
        CFG_COEF_Y: cy_q   <= cfg_data_i;
        CFG_COEF_Z: cz_q   <= cfg_data_i;
        CFG_SIZE_X: sx_q   <= cfg_data_i[8:0];
        CFG_SIZE_Y: sy_q   <= cfg_data_i[8:0];
        CFG_SIZE_Z: sz_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic en, acc;
  logic out_vld_q;
  assign en  = m_axis_tready || !out_vld_q;
  assign acc = s_axis_tvalid && en;
  assign s_axis_tready = en;

  pos_flags_t flags;
  logic [AW-1:0] wa, a_c, a_xp, a_xm, a_yp, a_ym, a_z;

  ds3_pos #(.MAX_ROW_LEN(MAX_ROW_LEN), .MAX_ROWS(MAX_ROWS)) u_pos (
    .clk_i, .rst_ni, .acc_i(acc),
    .size_x_i(sx_q), .size_y_i(sy_q), .size_z_i(sz_q),
    .flags_o(flags), .wr_addr_o(wa),
    .a_c_o(a_c), .a_xp_o(a_xp), .a_xm_o(a_xm),
    .a_yp_o(a_yp), .a_ym_o(a_ym), .a_z_o(a_z)
  );

  logic [31:0] w_c, w_xp, w_xm, w_yp, w_ym, w_z;

  ds3_win #(.AW(AW)) u_win0 (.clk_i, .en_i(en), .we_i(acc), .wa_i(wa),
    .wd_i(s_axis_tdata[31:0]), .ra0_i(a_c), .ra1_i(a_xp), .rd0_o(w_c), .rd1_o(w_xp));
  ds3_win #(.AW(AW)) u_win1 (.clk_i, .en_i(en), .we_i(acc), .wa_i(wa),
    .wd_i(s_axis_tdata[31:0]), .ra0_i(a_xm), .ra1_i(a_yp), .rd0_o(w_xm), .rd1_o(w_yp));
  ds3_win #(.AW(AW)) u_win2 (.clk_i, .en_i(en), .we_i(acc), .wa_i(wa),
    .wd_i(s_axis_tdata[31:0]), .ra0_i(a_ym), .ra1_i(a_z), .rd0_o(w_ym), .rd1_o(w_z));

  // sideband and valid line
  side_t side_q [SideN];
  logic  vld_q  [SideN];
  logic [31:0] cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SideN; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= acc && flags.emit;
      for (int i = 1; i < SideN; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0].inter <= flags.inter;
      side_q[0].tend  <= $signed(s_axis_tdata[63:32]);
      cur_q <= s_axis_tdata[31:0];
      for (int i = 1; i < SideN; i++) side_q[i] <= side_q[i-1];
    end
  end

  // second differences
  logic signed [34:0] dx_q, dy_q, dz_q;

  function automatic logic signed [34:0] d2(input logic [31:0] a, input logic [31:0] c,
                                             input logic [31:0] b);
    d2 = 35'($signed(a)) + 35'($signed(b)) - (35'($signed(c)) <<< 1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= d2(w_xp, w_c, w_xm);
      dy_q <= d2(w_yp, w_c, w_ym);
      dz_q <= d2(cur_q, w_c, w_z);
    end
  end

  logic signed [ProdW-1:0] px, py, pz, pv;
  logic signed [52:0]      lap_q;

  ds3_mulq #(.IW(35)) u_mx (.clk_i, .en_i(en), .s_i(dx_q), .c_i(cx_q), .p_o(px));
  ds3_mulq #(.IW(35)) u_my (.clk_i, .en_i(en), .s_i(dy_q), .c_i(cy_q), .p_o(py));
  ds3_mulq #(.IW(35)) u_mz (.clk_i, .en_i(en), .s_i(dz_q), .c_i(cz_q), .p_o(pz));

  always_ff @(posedge clk_i) begin
    if (en) lap_q <= 53'(px) + 53'(py) + 53'(pz);
  end

  ds3_mulq #(.IW(53)) u_mv (.clk_i, .en_i(en), .s_i(lap_q), .c_i(visc_q), .p_o(pv));

  // final sum and saturation
  logic signed [52:0] res;
  logic [31:0] tout_q;
  logic        inter_q, sat_q;
  logic        hi_sat, lo_sat;

  always_comb begin
    res    = 53'(side_q[SideN-1].tend) + 53'(pv);
    hi_sat = res > 53'sd2147483647;
    lo_sat = res < -53'sd2147483648;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= vld_q[SideN-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inter_q <= side_q[SideN-1].inter;
      if (!side_q[SideN-1].inter) begin
        tout_q <= side_q[SideN-1].tend;
        sat_q  <= 1'b0;
      end else if (hi_sat) begin
        tout_q <= 32'h7FFF_FFFF;
        sat_q  <= 1'b1;
      end else if (lo_sat) begin
        tout_q <= 32'h8000_0000;
        sat_q  <= 1'b1;
      end else begin
        tout_q <= res[31:0];
        sat_q  <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, sat_q, inter_q, tout_q};

endmodule

// ===== rtl/ds3_pos.sv =====
// ----------------------------------------------------------------------------
// ds3_pos
// Raster position counters, interior test and window addresses.
// ----------------------------------------------------------------------------
module ds3_pos import ds3_pkg::*; #(
  parameter int unsigned MAX_ROW_LEN = MaxRowLenDef,
  parameter int unsigned MAX_ROWS    = MaxRowsDef,
  localparam int unsigned XW = $clog2(MAX_ROW_LEN),
  localparam int unsigned YW = $clog2(MAX_ROWS),
  localparam int unsigned AW = 1 + XW + YW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  logic [8:0]    size_x_i,
  input  logic [8:0]    size_y_i,
  input  logic [15:0]   size_z_i,
  output pos_flags_t    flags_o,
  output logic [AW-1:0] wr_addr_o,
  output logic [AW-1:0] a_c_o,
  output logic [AW-1:0] a_xp_o,
  output logic [AW-1:0] a_xm_o,
  output logic [AW-1:0] a_yp_o,
  output logic [AW-1:0] a_ym_o,
  output logic [AW-1:0] a_z_o
);

  logic [XW-1:0] col_q, col_d, x;
  logic [YW-1:0] row_q, row_d, y;
  logic [15:0]   pln_q, pln_d, k, k1;
  logic [XW:0]   sx, x1;
  logic [YW:0]   sy, y1;
  logic [15:0]   sz;
  logic          pc;

  always_comb begin
    if (size_x_i < 9'd3) sx = (XW+1)'(3);
    else if (32'(size_x_i) > MAX_ROW_LEN) sx = (XW+1)'(MAX_ROW_LEN);
    else sx = (XW+1)'(size_x_i);
    if (size_y_i < 9'd3) sy = (YW+1)'(3);
    else if (32'(size_y_i) > MAX_ROWS) sy = (YW+1)'(MAX_ROWS);
    else sy = (YW+1)'(size_y_i);
    sz = (size_z_i < 16'd3) ? 16'd3 : size_z_i;

    // positions beyond a shrunken size restart at zero
    x = ({1'b0, col_q} >= sx) ? '0 : col_q;
    y = ({1'b0, row_q} >= sy) ? '0 : row_q;
    k = (pln_q >= sz) ? '0 : pln_q;
    x1 = {1'b0, x} + (XW+1)'(1);
    y1 = {1'b0, y} + (YW+1)'(1);
    k1 = k + 16'd1;

    col_d = x; row_d = y; pln_d = k;
    if (x1 >= sx) begin
      col_d = '0;
      if (y1 >= sy) begin
        row_d = '0;
        pln_d = (k1 >= sz) ? '0 : k1;
      end else begin
        row_d = y1[YW-1:0];
      end
    end else begin
      col_d = x1[XW-1:0];
    end

    flags_o.emit  = (k != 16'd0);
    flags_o.inter = (k >= 16'd2) && (x != '0) && (x1 < sx) && (y != '0) && (y1 < sy);

    pc = ~k[0];
    wr_addr_o = {k[0], y, x};
    a_z_o     = {k[0], y, x};
    a_c_o     = {pc, y, x};
    a_xp_o    = {pc, y, x1[XW-1:0]};
    a_xm_o    = {pc, y, x - XW'(1)};
    a_yp_o    = {pc, y1[YW-1:0], x};
    a_ym_o    = {pc, y - YW'(1), x};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      pln_q <= '0;
    end else if (acc_i) begin
      col_q <= col_d;
      row_q <= row_d;
      pln_q <= pln_d;
    end
  end

endmodule

// ===== rtl/ds3_win.sv =====
// ----------------------------------------------------------------------------
// ds3_win
// One copy of the two-plane window: one write port, two registered reads.
// ----------------------------------------------------------------------------
module ds3_win import ds3_pkg::*; #(
  parameter int unsigned AW = 17
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    wa_i,
  input  logic [DataW-1:0] wd_i,
  input  logic [AW-1:0]    ra0_i,
  input  logic [AW-1:0]    ra1_i,
  output logic [DataW-1:0] rd0_o,
  output logic [DataW-1:0] rd1_o
);

  logic [DataW-1:0] mem [2**AW];

  // read returns the old word when the same entry is written
  always_ff @(posedge clk_i) begin
    if (we_i) mem[wa_i] <= wd_i;
    if (en_i) begin
      rd0_o <= mem[ra0_i];
      rd1_o <= mem[ra1_i];
    end
  end

endmodule

// ===== rtl/ds3_mulq.sv =====
// ----------------------------------------------------------------------------
// ds3_mulq
// floor(s * c / 2^16) with magnitude clip, four register stages.
// ----------------------------------------------------------------------------
module ds3_mulq import ds3_pkg::*; #(
  parameter int unsigned IW = 35,
  localparam int unsigned HW = IW - 32
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [IW-1:0]    s_i,
  input  logic [31:0]             c_i,
  output logic signed [ProdW-1:0] p_o
);

  logic [IW-1:0]    m_a;
  logic             neg_a, neg_b, neg_c;
  logic [31:0]      c_a;
  logic [63:0]      lo_b;
  logic [HW+31:0]   hi_b;
  logic [50:0]      q_c;
  logic [48:0]      q;
  logic             inc, clip;

  always_comb begin
    inc  = neg_b && (lo_b[15:0] != 16'd0);
    clip = |hi_b[HW+31:32];
    q = 49'({hi_b[31:0], 16'd0}) + 49'(lo_b[63:16]) + 49'(inc);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_a <= s_i[IW-1];
      m_a   <= s_i[IW-1] ? IW'(-s_i) : IW'(s_i);
      c_a   <= c_i;
      neg_b <= neg_a;
      lo_b  <= 64'(m_a[31:0]) * 64'(c_a);
      hi_b  <= (HW+32)'(m_a[IW-1:32]) * (HW+32)'(c_a);
      neg_c <= neg_b;
      q_c   <= clip ? (51'd1 << 50) : 51'(q);
      p_o   <= neg_c ? -$signed({1'b0, q_c}) : $signed({1'b0, q_c});
    end
  end

endmodule

// ===== rtl/ds3_chk.sv =====
// ----------------------------------------------------------------------------
// ds3_chk
// Port-level checks on the result stream of the stencil block.
// ----------------------------------------------------------------------------
`include "diffusion_stencil_3d_assert.svh"

module ds3_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  `DS3_ASSERT(a_hold_valid, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `DS3_ASSERT(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[39:34] == 6'd0)
  `DS3_ASSERT_MSG(a_sat_inter, m_axis_tvalid && m_axis_tdata[33] |-> m_axis_tdata[32], "saturated boundary cell")
  `DS3_ASSERT_MSG(a_sat_rail, m_axis_tvalid && m_axis_tdata[33] |-> m_axis_tdata[31:0] == 32'h7FFF_FFFF || m_axis_tdata[31:0] == 32'h8000_0000, "saturated value off rail")

endmodule

bind diffusion_stencil_3d ds3_chk u_ds3_chk (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
